FILE: rtl/nfp_pkg.sv
// ----------------------------------------------------------------------------
// nfp_pkg: shared constants, types and helpers of the Newton fractal pixel block
// Fixed-point formats, the micro-program of the shared multiplier and the
// request and response of the divider.
// ----------------------------------------------------------------------------
`default_nettype none
package nfp_pkg;

  localparam int FRAC = 24;            // fractional bits of Q8.24
  localparam int QW   = 32;            // width of one Q8.24 value
  localparam int AW   = 66;            // accumulator width for two products
  localparam int DW   = 96;            // divider remainder width

  localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [AW-1:0] QONE = AW'(1) <<< FRAC;
  localparam logic signed [AW-1:0] QTWO = AW'(2) <<< FRAC;

  // Configuration register indexes.
  localparam logic [2:0] REG_X_STEP    = 3'd0;
  localparam logic [2:0] REG_Y_STEP    = 3'd1;
  localparam logic [2:0] REG_HEIGHT    = 3'd2;
  localparam logic [2:0] REG_MAX_ITER  = 3'd3;
  localparam logic [2:0] REG_THRESHOLD = 3'd4;

  // Multiplier operand codes.
  localparam logic [2:0] OP_ZR  = 3'd0;
  localparam logic [2:0] OP_ZI  = 3'd1;
  localparam logic [2:0] OP_Z2R = 3'd2;
  localparam logic [2:0] OP_Z2I = 3'd3;
  localparam logic [2:0] OP_NR  = 3'd4;
  localparam logic [2:0] OP_NI  = 3'd5;
  localparam logic [2:0] OP_DR  = 3'd6;
  localparam logic [2:0] OP_DI  = 3'd7;

  typedef struct packed {
    logic                 start;
    logic signed [AW-1:0] num;
    logic        [63:0]   den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [QW-1:0] quot;
  } div_rsp_t;

  // First operand of micro-op k.
  function automatic logic [2:0] op_a(input logic [3:0] k);
    case (k)
      4'd0, 4'd2:   op_a = OP_ZR;
      4'd1, 4'd3:   op_a = OP_ZI;
      4'd4, 4'd6:   op_a = OP_Z2R;
      4'd5, 4'd7:   op_a = OP_Z2I;
      4'd8, 4'd12:  op_a = OP_NR;
      4'd9, 4'd13:  op_a = OP_NI;
      4'd10:        op_a = OP_DR;
      4'd11:        op_a = OP_DI;
      4'd14:        op_a = OP_NI;
      default:      op_a = OP_NR;
    endcase
  endfunction

  // Second operand of micro-op k.
  function automatic logic [2:0] op_b(input logic [3:0] k);
    case (k)
      4'd0, 4'd3, 4'd7:          op_b = OP_ZR;
      4'd1, 4'd2, 4'd6, 4'd5:    op_b = OP_ZI;
      4'd4:                      op_b = OP_ZR;
      4'd8:                      op_b = OP_NR;
      4'd9:                      op_b = OP_NI;
      4'd10, 4'd12, 4'd14:       op_b = OP_DR;
      default:                   op_b = OP_DI;
    endcase
  endfunction

  // Odd micro-ops that subtract their product instead of adding it.
  function automatic logic op_sub(input logic [3:0] k);
    case (k)
      4'd1, 4'd5, 4'd15: op_sub = 1'b1;
      default:           op_sub = 1'b0;
    endcase
  endfunction

  // Saturate a wide signed value to Q8.24.
  function automatic logic signed [QW-1:0] sat_q(input logic signed [AW-1:0] v);
    if (v > $signed({{(AW-QW){1'b0}}, QMAX})) begin
      sat_q = QMAX;
    end else if (v < $signed({{(AW-QW){1'b1}}, QMIN})) begin
      sat_q = QMIN;
    end else begin
      sat_q = v[QW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/nfp_divider.sv
// ----------------------------------------------------------------------------
// nfp_divider: radix-2 restoring divider for the Newton quotient
// Gives num * 2^24 / den truncated toward zero, saturated to Q8.24, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module nfp_divider (
  input  wire                clk,
  input  wire                rst,
  input  nfp_pkg::div_req_t  req,
  output nfp_pkg::div_rsp_t  rsp
);

  logic                          running;
  logic                          neg;
  logic [4:0]                    cnt;
  logic [nfp_pkg::DW-1:0]        rem;
  logic [nfp_pkg::DW-1:0]        dsh;
  logic [nfp_pkg::QW-1:0]        q;
  logic signed [nfp_pkg::AW-1:0] nmag;
  logic                          fits;
  logic [nfp_pkg::QW-1:0]        q_fin;
  logic                          sat;

  assign nmag = req.num[nfp_pkg::AW-1] ? -req.num : req.num;
  assign fits = rem >= dsh;
  // A quotient bit at the top position means the result is out of range.
  assign sat  = fits && (cnt == 5'd31);

  always_comb begin
    q_fin = q;
    if (fits) begin
      q_fin[cnt] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        neg     <= req.num[nfp_pkg::AW-1];
        rem     <= {7'b0, nmag[64:0], {nfp_pkg::FRAC{1'b0}}};
        dsh     <= {1'b0, req.den, 31'b0};
        cnt     <= 5'd31;
        q       <= '0;
      end else if (running) begin
        if (fits) begin
          rem <= rem - dsh;
        end
        dsh <= dsh >> 1;
        q   <= q_fin;
        cnt <= cnt - 5'd1;
        if (sat || cnt == 5'd0) begin
          running  <= 1'b0;
          rsp.done <= 1'b1;
          if (neg) begin
            rsp.quot <= sat ? nfp_pkg::QMIN : -$signed(q_fin);
          end else begin
            rsp.quot <= sat ? nfp_pkg::QMAX : $signed(q_fin);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/newton_fractal_pixel_top.sv
// ----------------------------------------------------------------------------
// newton_fractal_pixel_top: Newton fractal of z^3 - 1, one pixel per command
// Maps a pixel to a Q8.24 start point, iterates Newton steps on one shared
// multiplier and one shared divider, and colors the pixel.
// ----------------------------------------------------------------------------
// A pixel is taken when start is high and busy is low; busy then stays high
// until the cycle in which the result is shown. The result appears for one
// cycle with done high and must be captured then, since the receiver cannot
// stall the block. Each Newton step runs sixteen products through the single
// 32x32 multiplier, each formed in S_MUL and summed in S_ACC, and two
// divides, launched and handed back in S_DIV, that make one quotient bit
// at a time and end early on saturation. busy also covers the coloring of
// a converged pixel. The user must write configuration only while busy is
// low; the block itself does not enforce this.
`default_nettype none
module newton_fractal_pixel_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [11:0] column,
  input  wire  [11:0] row,
  output logic        done,
  output logic [11:0] pixel_x,
  output logic [12:0] pixel_y,
  output logic [7:0]  iterations,
  output logic        converged,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [26:0] cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_COLOR = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam int QW = nfp_pkg::QW;
  localparam int AW = nfp_pkg::AW;

  logic [26:0] x_step, y_step;
  logic [12:0] image_height;
  logic [7:0]  max_iterations;
  logic [24:0] converge_threshold;

  logic [2:0]  state;
  logic [3:0]  k;
  logic [7:0]  iter;
  logic        conv;
  logic [11:0] px, prow;

  logic signed [QW-1:0] zr, zi, z2r, z2i, nr, ni, dr, di;
  logic signed [QW-1:0] mul_a, mul_b;
  logic signed [63:0]   prod;
  logic signed [AW-1:0] acc, acc_next, addend, shifted, thr;
  logic signed [QW-1:0] grp_q, nr_q, dr_q, di_q;
  logic signed [AW-1:0] z2r_e, z2i_e;
  logic [39:0]          xprod, yprod;

  logic [16:0] crem;
  logic [2:0]  ccnt;
  logic [16:0] cden_sh;
  logic [16:0] cnum;

  nfp_pkg::div_req_t div_req;
  nfp_pkg::div_rsp_t div_rsp;

  nfp_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_step             <= 27'd263172;
      y_step             <= 27'd263172;
      image_height       <= 13'd256;
      max_iterations     <= 8'd15;
      converge_threshold <= 25'd17;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nfp_pkg::REG_X_STEP:    x_step             <= cfg_data;
        nfp_pkg::REG_Y_STEP:    y_step             <= cfg_data;
        nfp_pkg::REG_HEIGHT:    image_height       <= cfg_data[12:0];
        nfp_pkg::REG_MAX_ITER:  max_iterations     <= cfg_data[7:0];
        nfp_pkg::REG_THRESHOLD: converge_threshold <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  function automatic logic signed [QW-1:0] pick(
    input logic [2:0] sel,
    input logic signed [QW-1:0] a0, a1, a2, a3, a4, a5, a6, a7
  );
    case (sel)
      nfp_pkg::OP_ZR:  pick = a0;
      nfp_pkg::OP_ZI:  pick = a1;
      nfp_pkg::OP_Z2R: pick = a2;
      nfp_pkg::OP_Z2I: pick = a3;
      nfp_pkg::OP_NR:  pick = a4;
      nfp_pkg::OP_NI:  pick = a5;
      nfp_pkg::OP_DR:  pick = a6;
      default:         pick = a7;
    endcase
  endfunction

  assign mul_a = pick(nfp_pkg::op_a(k), zr, zi, z2r, z2i, nr, ni, dr, di);
  assign mul_b = pick(nfp_pkg::op_b(k), zr, zi, z2r, z2i, nr, ni, dr, di);

  always_comb begin
    addend = {{(AW-64){prod[63]}}, prod};
    if (!k[0]) begin
      acc_next = addend;
    end else if (nfp_pkg::op_sub(k)) begin
      acc_next = acc - addend;
    end else begin
      acc_next = acc + addend;
    end
  end

  assign shifted = acc_next >>> nfp_pkg::FRAC;
  assign grp_q   = nfp_pkg::sat_q(shifted);
  assign nr_q    = nfp_pkg::sat_q({{(AW-QW){grp_q[QW-1]}}, grp_q} - nfp_pkg::QONE);
  assign z2r_e   = {{(AW-QW){z2r[QW-1]}}, z2r};
  assign z2i_e   = {{(AW-QW){z2i[QW-1]}}, z2i};
  assign dr_q    = nfp_pkg::sat_q(z2r_e + (z2r_e <<< 1));
  assign di_q    = nfp_pkg::sat_q(z2i_e + (z2i_e <<< 1));
  assign thr     = $signed({17'b0, converge_threshold, {nfp_pkg::FRAC{1'b0}}});

  assign xprod = 40'(x_step) * 40'(column);
  assign yprod = 40'(y_step) * 40'(row);

  assign cnum    = 17'(iter) * 17'd510 + 17'(max_iterations);
  assign cden_sh = 17'({max_iterations, 1'b0}) << ccnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      done          <= 1'b0;
      div_req.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            px    <= column;
            prow  <= row;
            zr    <= nfp_pkg::sat_q($signed({26'b0, xprod}) - nfp_pkg::QTWO);
            zi    <= nfp_pkg::sat_q($signed({26'b0, yprod}) - nfp_pkg::QTWO);
            iter  <= 8'd0;
            k     <= 4'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mul_a * mul_b;
          state <= S_ACC;
        end
        S_ACC: begin
          acc   <= acc_next;
          k     <= k + 4'd1;
          state <= S_MUL;
          case (k)
            4'd1: z2r <= grp_q;
            4'd3: z2i <= grp_q;
            4'd5: nr  <= nr_q;
            4'd7: ni  <= grp_q;
            4'd9: begin
              if (iter >= max_iterations || acc_next <= thr) begin
                conv <= (iter < max_iterations);
                ccnt <= 3'd7;
                crem <= cnum;
                red  <= 8'd0;
                state <= (iter < max_iterations) ? S_COLOR : S_OUT;
              end else if (dr_q == '0 && di_q == '0) begin
                // Zero denominator: stop without convergence.
                conv  <= 1'b0;
                state <= S_OUT;
              end else begin
                dr <= dr_q;
                di <= di_q;
              end
            end
            4'd11: div_req.den <= acc_next[63:0];
            4'd13, 4'd15: begin
              div_req.start <= 1'b1;
              div_req.num   <= acc_next;
              state         <= S_DIV;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_MUL;
            if (k == 4'd14) begin
              zr <= nfp_pkg::sat_q({{(AW-QW){zr[QW-1]}}, zr}
                                   - {{(AW-QW){div_rsp.quot[QW-1]}}, div_rsp.quot});
            end else begin
              zi   <= nfp_pkg::sat_q({{(AW-QW){zi[QW-1]}}, zi}
                                     - {{(AW-QW){div_rsp.quot[QW-1]}}, div_rsp.quot});
              iter <= iter + 8'd1;
            end
          end
        end
        S_COLOR: begin
          if (crem >= cden_sh) begin
            crem      <= crem - cden_sh;
            red[ccnt] <= 1'b1;
          end
          ccnt <= ccnt - 3'd1;
          if (ccnt == 3'd0) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          pixel_x    <= px;
          pixel_y    <= image_height - 13'(prow);
          iterations <= iter;
          converged  <= conv;
          green      <= conv ? 8'd128 : 8'd0;
          blue       <= conv ? 8'd255 - red : 8'd0;
          if (!conv) begin
            red <= 8'd0;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/nfp_checker.sv
// ----------------------------------------------------------------------------
// nfp_checker: port-level checks of the Newton fractal pixel block
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module nfp_checker (
  input wire       clk,
  input wire       rst,
  input wire       start,
  input wire       busy,
  input wire       done,
  input wire       converged,
  input wire [7:0] red,
  input wire [7:0] green,
  input wire [7:0] blue
);

  // An accepted transaction keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy did not rise after accept");

  // A result is only shown once the block has finished its work.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_black: assert property (@(posedge clk) disable iff (rst)
    done && !converged |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
    else $error("non-converged pixel is not black");

  a_color: assert property (@(posedge clk) disable iff (rst)
    done && converged |-> green == 8'd128 && (9'(red) + 9'(blue)) == 9'd255)
    else $error("converged pixel color mismatch");

endmodule

bind newton_fractal_pixel_top nfp_checker u_nfp_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .converged (converged),
  .red       (red),
  .green     (green),
  .blue      (blue)
);
`default_nettype wire

FILE: tb/sv/tb_newton_fractal_pixel_top.sv
// ----------------------------------------------------------------------------
// tb_newton_fractal_pixel_top: self-checking bench of the Newton fractal pixel
// Sends pixel commands under several register settings, predicts every
// result with a bit-exact fixed-point Newton model and checks each field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_newton_fractal_pixel_top;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [11:0] px;
    logic [12:0] py;
    logic [7:0]  iter;
    logic        conv;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } pixel_t;

  localparam wide_t Q_HI = 2147483647;
  localparam wide_t Q_LO = -Q_HI - 1;
  localparam wide_t Q_ONE = 16777216;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [11:0] pix_col = '0;
  logic [11:0] pix_row = '0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = nfp_pkg::REG_X_STEP;
  logic [26:0] cfg_data = '0;
  logic        busy, done, converged, cfg_ready;
  logic [11:0] pixel_x;
  logic [12:0] pixel_y;
  logic [7:0]  iterations, red, green, blue;

  // Shadow copy of the configuration registers.
  logic [26:0] x_step_q = 27'd263172;
  logic [26:0] y_step_q = 27'd263172;
  logic [12:0] height_q = 13'd256;
  logic [7:0]  max_iter_q = 8'd15;
  logic [24:0] thresh_q = 25'd17;

  pixel_t expected_pixels[$];
  int     mismatches = 0;

  always #6 clk = ~clk;

  newton_fractal_pixel_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .column(pix_col), .row(pix_row), .done(done),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .iterations(iterations),
    .converged(converged), .red(red), .green(green), .blue(blue),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic logic signed [31:0] sat_q8(input wide_t v);
    if (v > Q_HI) return Q_HI[31:0];
    if (v < Q_LO) return Q_LO[31:0];
    return v[31:0];
  endfunction

  // (a*b +/- c*d) floored back to Q8.24 and saturated.
  function automatic logic signed [31:0] mul_pair(input logic signed [31:0] a,
      input logic signed [31:0] b, input logic signed [31:0] c,
      input logic signed [31:0] d, input logic sub);
    wide_t p, e;
    p = wide_t'(a) * wide_t'(b);
    e = wide_t'(c) * wide_t'(d);
    return sat_q8(sub ? ((p - e) >>> 24) : ((p + e) >>> 24));
  endfunction

  // num * 2^24 / den truncated toward zero, saturated per component.
  function automatic logic signed [31:0] quot_q8(input wide_t num, input wide_t den);
    logic [255:0] m, q;
    m = (num < 0) ? 256'(-num) : 256'(num);
    q = (m << 24) / 256'(den);
    if (q > 256'h8000_0000) q = 256'h8000_0000;
    if (num < 0) return -q[31:0];
    return (q > 256'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
  endfunction

  function automatic pixel_t newton_pixel(input logic [11:0] col, input logic [11:0] rw);
    logic signed [31:0] zr, zi, z2r, z2i, nr, ni, dr, di;
    wide_t  den, nre, nim, thr;
    int     iter, lim;
    logic   zdiv, in_bound;
    pixel_t p;
    lim = max_iter_q;
    iter = 0;
    zdiv = 1'b0;
    thr = wide_t'(thresh_q) <<< 24;
    zr = sat_q8(-2 * Q_ONE + wide_t'(x_step_q) * wide_t'(col));
    zi = sat_q8(-2 * Q_ONE + wide_t'(y_step_q) * wide_t'(rw));
    forever begin
      z2r = mul_pair(zr, zr, zi, zi, 1'b1);
      z2i = mul_pair(zr, zi, zi, zr, 1'b0);
      nr = sat_q8(wide_t'(mul_pair(z2r, zr, z2i, zi, 1'b1)) - Q_ONE);
      ni = mul_pair(z2r, zi, z2i, zr, 1'b0);
      in_bound = (wide_t'(nr) * wide_t'(nr) + wide_t'(ni) * wide_t'(ni)) <= thr;
      if (iter >= lim || in_bound) break;
      dr = sat_q8(wide_t'(z2r) * 3);
      di = sat_q8(wide_t'(z2i) * 3);
      if (dr == 0 && di == 0) begin
        zdiv = 1'b1;
        break;
      end
      den = wide_t'(dr) * wide_t'(dr) + wide_t'(di) * wide_t'(di);
      nre = wide_t'(nr) * wide_t'(dr) + wide_t'(ni) * wide_t'(di);
      nim = wide_t'(ni) * wide_t'(dr) - wide_t'(nr) * wide_t'(di);
      zr = sat_q8(wide_t'(zr) - wide_t'(quot_q8(nre, den)));
      zi = sat_q8(wide_t'(zi) - wide_t'(quot_q8(nim, den)));
      iter++;
    end
    p.px = col;
    p.py = height_q - 13'(rw);
    p.iter = 8'(iter);
    p.conv = !zdiv && iter < lim;
    p.r = p.conv ? 8'((510 * iter + lim) / (2 * lim)) : 8'd0;
    p.g = p.conv ? 8'd128 : 8'd0;
    p.b = p.conv ? 8'd255 - p.r : 8'd0;
    return p;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d (time %0t)", field, got, want, $time);
    mismatches++;
  endtask

  // Every result is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    pixel_t e;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = expected_pixels.pop_front();
        if (pixel_x !== e.px) report_mismatch("pixel_x", pixel_x, e.px);
        if (pixel_y !== e.py) report_mismatch("pixel_y", pixel_y, e.py);
        if (iterations !== e.iter) report_mismatch("iterations", iterations, e.iter);
        if (converged !== e.conv) report_mismatch("converged", converged, e.conv);
        if (red !== e.r) report_mismatch("red", red, e.r);
        if (green !== e.g) report_mismatch("green", green, e.g);
        if (blue !== e.b) report_mismatch("blue", blue, e.b);
      end
    end
  end

  function automatic int idle_gap();
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) return 0;
    if (sel < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_pixel(input logic [11:0] col, input logic [11:0] rw);
    int gap;
    start <= 1'b1;
    pix_col <= col;
    pix_row <= rw;
    do @(posedge clk); while (busy);
    expected_pixels.push_back(newton_pixel(col, rw));
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    start <= 1'b0;
    while (expected_pixels.size() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Back-to-back writes keep valid high; a gap drops it first.
  task automatic write_reg(input logic [2:0] idx, input logic [26:0] val);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      nfp_pkg::REG_X_STEP:    x_step_q = val;
      nfp_pkg::REG_Y_STEP:    y_step_q = val;
      nfp_pkg::REG_HEIGHT:    height_q = val[12:0];
      nfp_pkg::REG_MAX_ITER:  max_iter_q = val[7:0];
      nfp_pkg::REG_THRESHOLD: thresh_q = val[24:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [26:0] xs, input logic [26:0] ys,
      input logic [12:0] ht, input logic [7:0] mi, input logic [24:0] th);
    wait_idle();
    write_reg(nfp_pkg::REG_X_STEP, xs);
    write_reg(nfp_pkg::REG_Y_STEP, ys);
    write_reg(nfp_pkg::REG_HEIGHT, 27'(ht));
    write_reg(nfp_pkg::REG_MAX_ITER, 27'(mi));
    write_reg(nfp_pkg::REG_THRESHOLD, 27'(th));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Corners, edges and the row flip under the reset configuration.
  task automatic test_reset_config();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd191, 12'd128);
    send_pixel(12'd64, 12'd200);
    send_pixel(12'd255, 12'd255);
    send_pixel(12'd300, 12'd2730);
  endtask

  // Register extremes: zero denominator, zero limit, saturating start points.
  task automatic test_register_extremes();
    // Origin start point gives a zero denominator on the first step.
    set_config(27'd8388608, 27'd8388608, 13'd0, 8'd1, 25'd0);
    send_pixel(12'd4, 12'd4);
    send_pixel(12'd5, 12'd4);
    set_config(27'd1, 27'd1, 13'd8191, 8'd0, 25'd33554431);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd1);
    set_config(27'd67108864, 27'd67108864, 13'd4096, 8'd255, 25'd16777216);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd3, 12'd0);
    send_pixel(12'd2, 12'd2);
    set_config(27'h7FFFFFF, 27'h7FFFFFF, 13'd1, 8'd255, 25'd17);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd0, 12'd1);
    set_config(27'd263172, 27'd263172, 13'd256, 8'd255, 25'd0);
    send_pixel(12'd200, 12'd130);
    send_pixel(12'd40, 12'd40);
  endtask

  // Random settings; most phases use a proper image grid, some raw noise.
  task automatic test_random_images();
    int w, h, n;
    logic [7:0]  mi;
    logic [24:0] th;
    for (int ph = 0; ph < 10; ph++) begin
      w = $urandom_range(2, 4096);
      h = $urandom_range(2, 4096);
      mi = (ph == 9) ? 8'd255 : 8'($urandom_range(1, 24));
      case ($urandom_range(3))
        0: th = 25'($urandom_range(0, 30));
        1: th = 25'($urandom_range(0, 5000));
        2: th = 25'($urandom);
        default: th = 25'd17;
      endcase
      if (ph % 4 == 3)
        set_config(27'($urandom), 27'($urandom), 13'($urandom), mi, th);
      else
        set_config(27'(67108864 / (w - 1)), 27'(67108864 / (h - 1)), 13'(h), mi, th);
      n = (ph == 9) ? 10 : 100;
      for (int k = 0; k < n; k++) begin
        if (ph % 4 == 3 || $urandom_range(9) == 0)
          send_pixel(12'($urandom), 12'($urandom));
        else
          send_pixel(12'($urandom_range(0, w - 1)), 12'($urandom_range(0, h - 1)));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_register_extremes();
    test_random_images();
    wait_idle();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #1000000000;
    $display("FAIL");
    $finish;
  end

endmodule
